// ===== hw/rtl/ter_pkg.sv =====
// ----------------------------------------------------------------------------
// ter_pkg
// Shared constants, codes and transfer types of the triangle edge rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ter_pkg;

  // largest screen dimension
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned SIZE_W    = 13;   // screen size register
  localparam int unsigned CRD_W     = 12;   // pixel coordinate
  localparam int unsigned NORM_W    = 16;   // Q2.14 vertex input
  localparam int unsigned SCR_W     = 14;   // signed screen vertex
  localparam int unsigned DIFF_W    = 15;   // edge operand
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(320);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(240);

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // one pixel test handed from the front to the back
  typedef struct packed {
    logic [CRD_W-1:0]            x;
    logic [CRD_W-1:0]            y;
    logic                        last;
    logic [2:0][SCR_W-1:0]       vx;
    logic [2:0][SCR_W-1:0]       vy;
  } ter_job_t;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic             covered;
    logic             last;
  } ter_pix_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ter_front.sv =====
// ----------------------------------------------------------------------------
// ter_front
// Accepts items, maps vertices to screen space, clips the bounding box and
// walks the box column-major, one pixel test per advance on an active scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ter_front import ter_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [SIZE_W-1:0]        cfg_wdata_i,
  input  wire logic                     push_i,
  output logic                          full_o,
  input  wire logic                     func_i,
  input  wire logic signed [NORM_W-1:0] v0_x_i,
  input  wire logic signed [NORM_W-1:0] v0_y_i,
  input  wire logic signed [NORM_W-1:0] v1_x_i,
  input  wire logic signed [NORM_W-1:0] v1_y_i,
  input  wire logic signed [NORM_W-1:0] v2_x_i,
  input  wire logic signed [NORM_W-1:0] v2_y_i,
  output ter_job_t                      job_o,
  output logic                          job_push_o,
  input  wire logic                     job_full_i
);

  // trunc_toward_zero((v + 16384) * size / 32768)
  function automatic logic signed [SCR_W-1:0] to_screen(
    input logic signed [NORM_W-1:0] v,
    input logic [SIZE_W-1:0]        size
  );
    logic signed [NORM_W:0]   off;
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] q;
    off = {v[NORM_W-1], v} + (NORM_W+1)'(16384);
    p   = off * $signed({1'b0, size});
    if (p < 0) begin
      p = p + PROD_W'(32767);
    end
    q = p >>> 15;
    return q[SCR_W-1:0];
  endfunction

  logic [SIZE_W-1:0] width_q, height_q;
  logic [SIZE_W-1:0] eff_w, eff_h;

  logic                    s1_valid_q;
  logic                    s1_func_q;
  logic signed [SCR_W-1:0] s1_sx_q [3];
  logic signed [SCR_W-1:0] s1_sy_q [3];
  logic                    accept, s1_take;

  logic signed [SCR_W-1:0] vx_q [3];
  logic signed [SCR_W-1:0] vy_q [3];
  logic [CRD_W-1:0]        min_x_q, max_x_q, min_y_q, max_y_q;
  logic [CRD_W-1:0]        cur_x_q, cur_y_q;
  logic                    scan_active_q;

  logic signed [SCR_W-1:0] mn_x, mx_x, mn_y, mx_y;
  logic signed [SCR_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [SCR_W-1:0] lim_x, lim_y;
  logic                    box_empty;
  logic                    fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = (width_q == '0) ? SIZE_W'(1) :
            (width_q > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : width_q;
    eff_h = (height_q == '0) ? SIZE_W'(1) :
            (height_q > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : height_q;
  end

  // stage 1: screen mapping, one multiplier per coordinate
  assign accept  = push_i && !full_o;
  assign s1_take = s1_valid_q &&
                   (s1_func_q == FUNC_LOAD || !scan_active_q || !job_full_i);
  assign full_o  = s1_valid_q && !s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !s1_take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q  <= func_i;
      s1_sx_q[0] <= to_screen(v0_x_i, eff_w);
      s1_sy_q[0] <= to_screen(v0_y_i, eff_h);
      s1_sx_q[1] <= to_screen(v1_x_i, eff_w);
      s1_sy_q[1] <= to_screen(v1_y_i, eff_h);
      s1_sx_q[2] <= to_screen(v2_x_i, eff_w);
      s1_sy_q[2] <= to_screen(v2_y_i, eff_h);
    end
  end

  // stage 2: bounding box and clip
  always_comb begin
    mn_x = s1_sx_q[0];
    mx_x = s1_sx_q[0];
    mn_y = s1_sy_q[0];
    mx_y = s1_sy_q[0];
    for (int i = 1; i < 3; i++) begin
      if (s1_sx_q[i] < mn_x) mn_x = s1_sx_q[i];
      if (s1_sx_q[i] > mx_x) mx_x = s1_sx_q[i];
      if (s1_sy_q[i] < mn_y) mn_y = s1_sy_q[i];
      if (s1_sy_q[i] > mx_y) mx_y = s1_sy_q[i];
    end
    lim_x     = $signed({1'b0, eff_w - SIZE_W'(1)});
    lim_y     = $signed({1'b0, eff_h - SIZE_W'(1)});
    lo_x      = (mn_x < 0) ? '0 : mn_x;
    lo_y      = (mn_y < 0) ? '0 : mn_y;
    hi_x      = (mx_x > lim_x) ? lim_x : mx_x;
    hi_y      = (mx_y > lim_y) ? lim_y : mx_y;
    box_empty = (lo_x > hi_x) || (lo_y > hi_y);
  end

  assign fin        = (cur_x_q == max_x_q) && (cur_y_q == max_y_q);
  assign job_push_o = s1_take && (s1_func_q == FUNC_ADVANCE) && scan_active_q;

  always_comb begin
    job_o.x    = cur_x_q;
    job_o.y    = cur_y_q;
    job_o.last = fin;
    for (int i = 0; i < 3; i++) begin
      job_o.vx[i] = vx_q[i];
      job_o.vy[i] = vy_q[i];
    end
  end

  // scan sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
      min_x_q       <= '0;
      max_x_q       <= '0;
      min_y_q       <= '0;
      max_y_q       <= '0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      scan_active_q <= 1'b0;
    end else if (s1_take) begin
      if (s1_func_q == FUNC_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          vx_q[i] <= s1_sx_q[i];
          vy_q[i] <= s1_sy_q[i];
        end
        if (box_empty) begin
          min_x_q       <= '0;
          max_x_q       <= '0;
          min_y_q       <= '0;
          max_y_q       <= '0;
          cur_x_q       <= '0;
          cur_y_q       <= '0;
          scan_active_q <= 1'b0;
        end else begin
          min_x_q       <= lo_x[CRD_W-1:0];
          max_x_q       <= hi_x[CRD_W-1:0];
          min_y_q       <= lo_y[CRD_W-1:0];
          max_y_q       <= hi_y[CRD_W-1:0];
          cur_x_q       <= lo_x[CRD_W-1:0];
          cur_y_q       <= lo_y[CRD_W-1:0];
          scan_active_q <= 1'b1;
        end
      end else if (scan_active_q) begin
        if (fin) begin
          scan_active_q <= 1'b0;
        end else if (cur_y_q < max_y_q) begin
          cur_y_q <= cur_y_q + CRD_W'(1);
        end else begin
          cur_y_q <= min_y_q;
          cur_x_q <= cur_x_q + CRD_W'(1);
        end
      end
    end
  end

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_active_q |-> (min_x_q <= max_x_q) && (min_y_q <= max_y_q))
    else $error("active scan with inverted box");

  a_pos_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_active_q |-> (cur_x_q >= min_x_q) && (cur_x_q <= max_x_q) &&
                      (cur_y_q >= min_y_q) && (cur_y_q <= max_y_q))
    else $error("scan position outside box");

  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_push_o && fin) |=> !scan_active_q)
    else $error("scan still active after last pixel");

endmodule

`default_nettype wire

// ===== hw/rtl/ter_job_q.sv =====
// ----------------------------------------------------------------------------
// ter_job_q
// Two-entry queue of pixel tests between the scan front and the edge back.
// ----------------------------------------------------------------------------
`default_nettype none

module ter_job_q import ter_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire ter_job_t job_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output ter_job_t      job_o,
  output logic          valid_o
);

  ter_job_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ter_back.sv =====
// ----------------------------------------------------------------------------
// ter_back
// Edge-function pipeline: operand differences, products, sign test, then a
// small result queue. Issue is credit-limited so the queue never overflows.
// ----------------------------------------------------------------------------
`default_nettype none

module ter_back import ter_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ter_job_t job_i,
  input  wire logic     job_valid_i,
  output logic          job_pop_o,
  output ter_pix_t      pix_o,
  output logic          empty_o,
  input  wire logic     pop_i
);

  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);

  // stage 1: differences
  logic                     s1_valid_q;
  logic [CRD_W-1:0]         s1_x_q, s1_y_q;
  logic                     s1_last_q;
  logic signed [DIFF_W-1:0] dvx_q [3], dpy_q [3], dvy_q [3], dpx_q [3];

  // stage 2: products
  logic                     s2_valid_q;
  logic [CRD_W-1:0]         s2_x_q, s2_y_q;
  logic                     s2_last_q;
  logic signed [PROD_W-1:0] pa_q [3], pb_q [3];
  logic [2:0]               edge_ok;

  ter_pix_t         fifo_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W:0]   in_use;
  logic             out_pop;
  ter_pix_t         wr_pix;

  assign in_use    = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(s1_valid_q) + (CNT_W+1)'(s2_valid_q);
  assign job_pop_o = job_valid_i && (in_use < (CNT_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= job_pop_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_edge
    // edge k runs from vertex U to vertex V
    localparam int U = (k + 1) % 3;
    localparam int V = (k + 2) % 3;
    logic signed [DIFF_W-1:0] ux, uy, vx, vy, px, py;

    assign ux = DIFF_W'($signed(job_i.vx[U]));
    assign uy = DIFF_W'($signed(job_i.vy[U]));
    assign vx = DIFF_W'($signed(job_i.vx[V]));
    assign vy = DIFF_W'($signed(job_i.vy[V]));
    assign px = $signed({{(DIFF_W-CRD_W){1'b0}}, job_i.x});
    assign py = $signed({{(DIFF_W-CRD_W){1'b0}}, job_i.y});

    always_ff @(posedge clk_i) begin
      if (job_pop_o) begin
        dvx_q[k] <= vx - ux;
        dpy_q[k] <= py - uy;
        dvy_q[k] <= vy - uy;
        dpx_q[k] <= px - ux;
      end
      if (s1_valid_q) begin
        pa_q[k] <= dvx_q[k] * dpy_q[k];
        pb_q[k] <= dvy_q[k] * dpx_q[k];
      end
    end

    assign edge_ok[k] = (pa_q[k] >= pb_q[k]);
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      s1_x_q    <= job_i.x;
      s1_y_q    <= job_i.y;
      s1_last_q <= job_i.last;
    end
    if (s1_valid_q) begin
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    wr_pix.x       = s2_x_q;
    wr_pix.y       = s2_y_q;
    wr_pix.covered = &edge_ok;
    wr_pix.last    = s2_last_q;
  end

  // result queue
  assign empty_o = (cnt_q == '0);
  assign pix_o   = fifo_q[rd_ptr_q];
  assign out_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      fifo_q[wr_ptr_q] <= wr_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s2_valid_q) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (out_pop)    rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(s2_valid_q) - CNT_W'(out_pop);
    end
  end

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use <= (CNT_W+1)'(OUT_DEPTH))
    else $error("results in flight exceed queue depth");

  a_write_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> !empty_o)
    else $error("written result not visible");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_pop && !s2_valid_q) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("result transfer did not drain queue");

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_edge_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// Edge-function triangle rasterizer with queue-style input and result ports.
// ----------------------------------------------------------------------------
// Sustains one item per clock: a load or an advance is taken every cycle as
// long as results are drained. A load maps its three vertices to screen space
// (one multiplier per coordinate) and clips the bounding box in the next cycle;
// an advance issued right after a load already sees the new box. Each advance
// on an active scan yields one pixel result, passing a two-entry pixel queue
// and a three-step edge pipeline (differences, six products, sign test) into a
// four-entry result queue. Advances while no scan is active and loads give no
// result. Screen size registers take effect at the next load.
`default_nettype none

module triangle_edge_rasterizer import ter_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [SIZE_W-1:0]        cfg_wdata_i,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     func_i,
  input  wire logic signed [NORM_W-1:0] v0_x_i,
  input  wire logic signed [NORM_W-1:0] v0_y_i,
  input  wire logic signed [NORM_W-1:0] v1_x_i,
  input  wire logic signed [NORM_W-1:0] v1_y_i,
  input  wire logic signed [NORM_W-1:0] v2_x_i,
  input  wire logic signed [NORM_W-1:0] v2_y_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [CRD_W-1:0]              pix_x_o,
  output logic [CRD_W-1:0]              pix_y_o,
  output logic                          covered_o,
  output logic                          last_o
);

  ter_job_t job_in, job_out;
  logic     job_push, job_full, job_pop, job_valid;
  ter_pix_t pix;

  ter_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .v0_x_i      (v0_x_i),
    .v0_y_i      (v0_y_i),
    .v1_x_i      (v1_x_i),
    .v1_y_i      (v1_y_i),
    .v2_x_i      (v2_x_i),
    .v2_y_i      (v2_y_i),
    .job_o       (job_in),
    .job_push_o  (job_push),
    .job_full_i  (job_full)
  );

  ter_job_q u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .valid_o (job_valid)
  );

  ter_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .pix_o       (pix),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign pix_x_o   = pix.x;
  assign pix_y_o   = pix.y;
  assign covered_o = pix.covered;
  assign last_o    = pix.last;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle edge rasterizer.
// ----------------------------------------------------------------------------
// Loads triangles and steps the scan one pixel at a time. A local model of the
// screen mapping, box clipping and edge tests predicts every pixel result, and
// a drain process compares the results in order. Directed cases come first, then
// a held-off output, size extremes, random triangles over several screen sizes.

module tb;
  import ter_pkg::*;

  localparam int SETTLE_CYCLES = 16;   // drain margin, a few times the latency

  typedef logic [5:0][NORM_W-1:0] tri_t;   // v0x, v0y, v1x, v1y, v2x, v2y

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [SIZE_W-1:0]        cfg_wdata_i = '0;
  logic                     push        = 1'b0;
  logic                     full;
  logic                     func_i      = FUNC_LOAD;
  logic signed [NORM_W-1:0] v0_x        = '0;
  logic signed [NORM_W-1:0] v0_y        = '0;
  logic signed [NORM_W-1:0] v1_x        = '0;
  logic signed [NORM_W-1:0] v1_y        = '0;
  logic signed [NORM_W-1:0] v2_x        = '0;
  logic signed [NORM_W-1:0] v2_y        = '0;
  logic                     empty;
  logic                     pop         = 1'b0;
  logic [CRD_W-1:0]         pix_x_o;
  logic [CRD_W-1:0]         pix_y_o;
  logic                     covered_o;
  logic                     last_o;

  // raster model state
  logic [SIZE_W-1:0]        scr_w_reg = RESET_WIDTH;
  logic [SIZE_W-1:0]        scr_h_reg = RESET_HEIGHT;
  logic signed [SCR_W-1:0]  vtx_sx [3];
  logic signed [SCR_W-1:0]  vtx_sy [3];
  logic [CRD_W-1:0]         box_x_lo, box_x_hi, box_y_lo, box_y_hi;
  logic [CRD_W-1:0]         scan_x, scan_y;
  bit                       scan_on = 1'b0;

  ter_pix_t pending_pixels [$];

  int unsigned gap_max     = 11;
  int          hold_left   = 0;
  int          errors      = 0;
  int          items_sent  = 0;
  int          loads_sent  = 0;
  int          pixels_seen = 0;
  int          inside_seen = 0;
  int          writes_done = 0;
  int          full_stalls = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  triangle_edge_rasterizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .v0_x_i      (v0_x),
    .v0_y_i      (v0_y),
    .v1_x_i      (v1_x),
    .v1_y_i      (v1_y),
    .v2_x_i      (v2_x),
    .v2_y_i      (v2_y),
    .empty       (empty),
    .pop         (pop),
    .pix_x_o     (pix_x_o),
    .pix_y_o     (pix_y_o),
    .covered_o   (covered_o),
    .last_o      (last_o)
  );

  // --------------------------------------------------------------------------
  // raster model
  // --------------------------------------------------------------------------
  function automatic int eff_dim(logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  // integer division truncates toward zero, as the mapping requires
  function automatic int map_to_screen(logic [NORM_W-1:0] raw, int dim);
    int p;
    p = (int'(signed'(raw)) + 16384) * dim;
    return p / 32768;
  endfunction

  function automatic void load_triangle(tri_t t);
    int w, h, lx, hx, ly, hy, sx, sy;
    w  = eff_dim(scr_w_reg);
    h  = eff_dim(scr_h_reg);
    lx = 1 << 30;
    ly = 1 << 30;
    hx = -(1 << 30);
    hy = -(1 << 30);
    for (int k = 0; k < 3; k++) begin
      sx = map_to_screen(t[2*k], w);
      sy = map_to_screen(t[2*k+1], h);
      vtx_sx[k] = SCR_W'(sx);
      vtx_sy[k] = SCR_W'(sy);
      lx = (sx < lx) ? sx : lx;
      hx = (sx > hx) ? sx : hx;
      ly = (sy < ly) ? sy : ly;
      hy = (sy > hy) ? sy : hy;
    end
    if (lx < 0) lx = 0;
    if (ly < 0) ly = 0;
    if (hx > w - 1) hx = w - 1;
    if (hy > h - 1) hy = h - 1;
    if (lx > hx || ly > hy) begin
      // wholly off screen: nothing to scan
      box_x_lo = '0;
      box_x_hi = '0;
      box_y_lo = '0;
      box_y_hi = '0;
      scan_x   = '0;
      scan_y   = '0;
      scan_on  = 1'b0;
    end else begin
      box_x_lo = CRD_W'(lx);
      box_x_hi = CRD_W'(hx);
      box_y_lo = CRD_W'(ly);
      box_y_hi = CRD_W'(hy);
      scan_x   = box_x_lo;
      scan_y   = box_y_lo;
      scan_on  = 1'b1;
    end
  endfunction

  function automatic longint edge_val(int a, int b, longint px, longint py);
    longint ax, ay;
    ax = longint'(vtx_sx[a]);
    ay = longint'(vtx_sy[a]);
    return (longint'(vtx_sx[b]) - ax) * (py - ay) - (longint'(vtx_sy[b]) - ay) * (px - ax);
  endfunction

  // one advance: column-major walk, y inner, both bounds inclusive
  function automatic bit step_scan(output ter_pix_t px);
    longint cx, cy;
    px = '0;
    if (!scan_on) return 1'b0;
    cx = longint'(scan_x);
    cy = longint'(scan_y);
    px.x       = scan_x;
    px.y       = scan_y;
    px.covered = edge_val(1, 2, cx, cy) >= 0 && edge_val(2, 0, cx, cy) >= 0 &&
                 edge_val(0, 1, cx, cy) >= 0;
    px.last    = (scan_x == box_x_hi) && (scan_y == box_y_hi);
    if (px.last) begin
      scan_on = 1'b0;
    end else if (scan_y < box_y_hi) begin
      scan_y++;
    end else begin
      scan_y = box_y_lo;
      scan_x++;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // triangle generators
  // --------------------------------------------------------------------------
  function automatic tri_t make_tri(int ax, int ay, int bx, int by, int cx, int cy);
    tri_t t;
    t[0] = NORM_W'(ax);
    t[1] = NORM_W'(ay);
    t[2] = NORM_W'(bx);
    t[3] = NORM_W'(by);
    t[4] = NORM_W'(cx);
    t[5] = NORM_W'(cy);
    return t;
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    for (int k = 0; k < 6; k++) t[k] = NORM_W'($urandom);
    return t;
  endfunction

  // on-screen center with a spread of about six pixels, so scans stay short
  function automatic tri_t near_tri();
    int sx, sy, cx, cy, v;
    tri_t t;
    sx = 196608 / eff_dim(scr_w_reg);
    sy = 196608 / eff_dim(scr_h_reg);
    if (sx > 32767) sx = 32767;
    if (sy > 32767) sy = 32767;
    cx = int'($urandom_range(0, 32767)) - 16384;
    cy = int'($urandom_range(0, 32767)) - 16384;
    for (int k = 0; k < 3; k++) begin
      v = cx + int'($urandom_range(0, 2 * sx)) - sx;
      v = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
      t[2*k] = NORM_W'(v);
      v = cy + int'($urandom_range(0, 2 * sy)) - sy;
      v = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
      t[2*k+1] = NORM_W'(v);
    end
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  task automatic send_item(logic func, tri_t t);
    int       gap;
    ter_pix_t px;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    push   = 1'b1;
    func_i = func;
    v0_x   = t[0];
    v0_y   = t[1];
    v1_x   = t[2];
    v1_y   = t[3];
    v2_x   = t[4];
    v2_y   = t[5];
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    items_sent++;
    if (func == FUNC_LOAD) begin
      load_triangle(t);
      loads_sent++;
    end else if (step_scan(px)) begin
      pending_pixels.push_back(px);
    end
  endtask

  task automatic finish_scan();
    while (scan_on) send_item(FUNC_ADVANCE, rand_tri());
  endtask

  // wait for all results, then let loads still in flight retire
  task automatic settle();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_screen(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    if (idx == REG_WIDTH) scr_w_reg = val;
    else if (idx == REG_HEIGHT) scr_h_reg = val;
    writes_done++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: check on the rising edge, drive pop on the falling edge
  // --------------------------------------------------------------------------
  initial begin : drain_results
    ter_pix_t got, want;
    int       stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.x       = pix_x_o;
        got.y       = pix_y_o;
        got.covered = covered_o;
        got.last    = last_o;
        if (pending_pixels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected pixel x=%0d y=%0d covered=%0b last=%0b",
                     $realtime, got.x, got.y, got.covered, got.last);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: exp x=%0d y=%0d cov=%0b last=%0b, got x=%0d y=%0d cov=%0b last=%0b",
                       $realtime, want.x, want.y, want.covered, want.last,
                       got.x, got.y, got.covered, got.last);
          end
        end
        pixels_seen++;
        if (got.covered) inside_seen++;
        stall = $urandom_range(0, gap_max);
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_default_screen();
    tri_t small_tri;
    small_tri = make_tri(0, 0, 200, 0, 0, 200);
    // advance before any load: no result
    send_item(FUNC_ADVANCE, rand_tri());
    send_item(FUNC_LOAD, small_tri);
    finish_scan();
    send_item(FUNC_ADVANCE, rand_tri());
    // single point: all edges zero, reported inside
    send_item(FUNC_LOAD, make_tri(0, 0, 0, 0, 0, 0));
    finish_scan();
    // off the right edge: empty box, advance ignored
    send_item(FUNC_LOAD, make_tri(32767, 0, 32767, 100, 32767, -100));
    send_item(FUNC_ADVANCE, rand_tri());
    // full-range vertices clip to the whole screen; replaced mid scan
    send_item(FUNC_LOAD, make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
    repeat (3) send_item(FUNC_ADVANCE, rand_tri());
    send_item(FUNC_LOAD, make_tri(0, 0, 0, 200, 200, 0));
    finish_scan();
    settle();
  endtask

  // output held off while the input keeps offering advances
  task automatic test_backpressure();
    settle();
    hold_left = 150;
    gap_max   = 0;
    send_item(FUNC_LOAD, make_tri(0, 0, 1000, 0, 0, 1000));
    repeat (40) send_item(FUNC_ADVANCE, rand_tri());
    gap_max   = 11;
    settle();
  endtask

  task automatic test_size_extremes();
    send_item(FUNC_LOAD, make_tri(0, 0, 200, 0, 0, 200));
    send_item(FUNC_ADVANCE, rand_tri());
    // new sizes must not disturb the running scan
    set_screen(REG_WIDTH, '0);
    set_screen(REG_HEIGHT, '1);
    finish_scan();
    send_item(FUNC_LOAD, near_tri());
    finish_scan();
    set_screen(REG_WIDTH, SIZE_W'(MAX_DIM));
    set_screen(REG_HEIGHT, SIZE_W'(1));
    send_item(FUNC_LOAD, near_tri());
    finish_scan();
    set_screen(REG_WIDTH, SIZE_W'(MAX_DIM + 1));
    set_screen(REG_HEIGHT, '0);
    send_item(FUNC_LOAD, near_tri());
    finish_scan();
    settle();
  endtask

  task automatic test_random_scans();
    int   widths  [8] = '{1, 0, 16, 320, 8191, 4096, 5, 4097};
    int   heights [8] = '{1, 4096, 9, 240, 8191, 0, 4096, 3};
    int   budget, kind, axis;
    tri_t t;
    for (int p = 0; p < 8; p++) begin
      set_screen(REG_WIDTH, SIZE_W'(widths[p]));
      set_screen(REG_HEIGHT, SIZE_W'(heights[p]));
      gap_max = (p == 3) ? 0 : 11;
      budget  = items_sent + 40;
      while (items_sent < budget) begin
        kind = $urandom_range(0, 9);
        t    = near_tri();
        if (kind <= 5) begin
          send_item(FUNC_LOAD, t);
          finish_scan();
          repeat ($urandom_range(0, 1)) send_item(FUNC_ADVANCE, rand_tri());
        end else if (kind == 6) begin
          // abandoned by the next load
          send_item(FUNC_LOAD, t);
          repeat ($urandom_range(0, 3)) send_item(FUNC_ADVANCE, rand_tri());
        end else if (kind == 7) begin
          // past the right or bottom edge on one axis
          axis = $urandom_range(0, 1);
          for (int k = 0; k < 3; k++) t[2*k+axis] = NORM_W'($urandom_range(16384, 32767));
          send_item(FUNC_LOAD, t);
          repeat ($urandom_range(0, 2)) send_item(FUNC_ADVANCE, rand_tri());
        end else if (kind == 8) begin
          if ($urandom_range(0, 1)) begin
            t[2] = t[0];
            t[3] = t[1];
            t[4] = t[0];
            t[5] = t[1];
          end else begin
            t[4] = NORM_W'((int'(signed'(t[0])) + int'(signed'(t[2]))) / 2);
            t[5] = NORM_W'((int'(signed'(t[1])) + int'(signed'(t[3]))) / 2);
          end
          send_item(FUNC_LOAD, t);
          finish_scan();
        end else begin
          send_item(FUNC_LOAD, rand_tri());
          repeat ($urandom_range(0, 4)) send_item(FUNC_ADVANCE, rand_tri());
        end
      end
    end
    gap_max = 11;
  endtask

  initial begin : run
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_screen();
    test_backpressure();
    test_size_extremes();
    test_random_scans();
    settle();
    $display("ran %0d items (%0d loads), checked %0d pixels, %0d inside the triangle",
             items_sent, loads_sent, pixels_seen, inside_seen);
    $display("%0d size register writes, %0d cycles with the input stalled by full",
             writes_done, full_stalls);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("timeout: %0d pixels still expected", pending_pixels.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
